// ----- sv/bbi_pkg.sv -----
// shared types, constants and defaults of the b-spline interpolator
`default_nettype none
package bbi_pkg;

  localparam int KNOT_STORE_DEPTH_DEF = 8192;
  localparam int FRACTION_BITS_DEF    = 12;

  localparam int COORD_W   = 16;
  localparam int SCALE_W   = 24;
  localparam int XCNT_W    = 8;
  localparam int YCNT_W    = 7;
  localparam int IDX_W     = 13;
  localparam int KNOT_W    = 16;
  localparam int OUT_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 24;

  // saturated bin width and position of the bin in the scaled coordinate
  localparam int BIN_W     = 8;
  localparam int BIN_SHIFT = 27;

  localparam int QUEUE_DEPTH = 4;

  // queued word without its two fractions
  localparam int JOB_FIXED_W = 1 + IDX_W + KNOT_W + 1 + 2 * BIN_W;

  localparam logic [COORD_W-1:0] ORIGIN_X_RST    = 16'd3840;
  localparam logic [COORD_W-1:0] ORIGIN_Y_RST    = 16'd3840;
  localparam logic [SCALE_W-1:0] X_SCALE_RST     = 24'd206540;
  localparam logic [SCALE_W-1:0] Y_SCALE_RST     = 24'd209715;
  localparam logic [XCNT_W-1:0]  X_KNOT_CNT_RST  = 8'd65;
  localparam logic [YCNT_W-1:0]  Y_KNOT_CNT_RST  = 7'd24;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X   = 3'd0,
    CFG_ORIGIN_Y   = 3'd1,
    CFG_X_SCALE    = 3'd2,
    CFG_Y_SCALE    = 3'd3,
    CFG_X_KNOT_CNT = 3'd4,
    CFG_Y_KNOT_CNT = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_WEIGH,
    BK_RUN,
    BK_DRAIN,
    BK_DONE
  } back_state_e;

endpackage
`default_nettype wire

// ----- sv/bbi_ram.sv -----
// generic single write port ram with registered read
`default_nettype none
module bbi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- sv/bbi_front.sv -----
// front end: takes words, scales points into bins and fractions, feeds the queue
`default_nettype none
module bbi_front #(
  parameter int FRACTION_BITS = bbi_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic                                  kind_i,
  input  wire logic [bbi_pkg::IDX_W-1:0]             knot_index_i,
  input  wire logic signed [bbi_pkg::KNOT_W-1:0]     knot_value_i,
  input  wire logic [bbi_pkg::COORD_W-1:0]           point_x_i,
  input  wire logic [bbi_pkg::COORD_W-1:0]           point_y_i,
  input  wire logic [bbi_pkg::COORD_W-1:0]           origin_x_i,
  input  wire logic [bbi_pkg::COORD_W-1:0]           origin_y_i,
  input  wire logic [bbi_pkg::SCALE_W-1:0]           x_scale_i,
  input  wire logic [bbi_pkg::SCALE_W-1:0]           y_scale_i,
  input  wire logic [bbi_pkg::XCNT_W-1:0]            x_cnt_i,
  input  wire logic [bbi_pkg::YCNT_W-1:0]            y_cnt_i,
  input  wire logic                                  full_i,
  output logic                                       push_o,
  output logic [bbi_pkg::JOB_FIXED_W+2*FRACTION_BITS-1:0] job_o
);
  import bbi_pkg::*;

  localparam int F      = FRACTION_BITS;
  localparam int PROD_W = COORD_W + SCALE_W;
  localparam int RAW_W  = PROD_W - BIN_SHIFT;

  logic                      s_valid_q, s_valid_d;
  logic                      s_kind_q;
  logic [IDX_W-1:0]          s_idx_q;
  logic signed [KNOT_W-1:0]  s_val_q;
  logic [COORD_W-1:0]        s_px_q, s_py_q;
  logic                      accept;

  logic [COORD_W-1:0]        dx, dy;
  logic [PROD_W-1:0]         prod_x, prod_y;
  logic [BIN_W-1:0]          x_last, y_last, bx, by;
  logic [F-1:0]              fx, fy;
  logic                      xzero;

  assign in_stall_o = s_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = s_valid_q && !full_i;
  assign s_valid_d  = accept || (s_valid_q && full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= s_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_kind_q <= kind_i;
      s_idx_q  <= knot_index_i;
      s_val_q  <= knot_value_i;
      s_px_q   <= point_x_i;
      s_py_q   <= point_y_i;
    end
  end

  // offset from origin, clamped at zero, then scaled into bin space
  always_comb begin
    dx     = (s_px_q > origin_x_i) ? s_px_q - origin_x_i : '0;
    dy     = (s_py_q > origin_y_i) ? s_py_q - origin_y_i : '0;
    prod_x = PROD_W'(dx) * PROD_W'(x_scale_i);
    prod_y = PROD_W'(dy) * PROD_W'(y_scale_i);
    xzero  = (x_cnt_i == '0);
    x_last = BIN_W'(x_cnt_i) - BIN_W'(1);
    y_last = BIN_W'(y_cnt_i) + BIN_W'(2);
    if (prod_x[PROD_W-1:BIN_SHIFT] > RAW_W'(x_last)) begin
      bx = x_last;
      fx = '1;
    end else begin
      bx = BIN_W'(prod_x[PROD_W-1:BIN_SHIFT]);
      fx = prod_x[BIN_SHIFT-1 -: F];
    end
    if (prod_y[PROD_W-1:BIN_SHIFT] > RAW_W'(y_last)) begin
      by = y_last;
      fy = '1;
    end else begin
      by = BIN_W'(prod_y[PROD_W-1:BIN_SHIFT]);
      fy = prod_y[BIN_SHIFT-1 -: F];
    end
  end

  assign job_o = {s_kind_q, s_idx_q, s_val_q, xzero, bx, fx, by, fy};

endmodule
`default_nettype wire

// ----- sv/bbi_fifo.sv -----
// short queue between front and back
`default_nettype none
module bbi_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bbi_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ----- sv/bbi_weights.sv -----
// cubic b-spline weights of one fraction, in a pipeline
`default_nettype none
module bbi_weights #(
  parameter int FRACTION_BITS = bbi_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [FRACTION_BITS-1:0]     frac_i,
  output logic                              done_o,
  output logic [3:0][FRACTION_BITS:0]       w_o
);

  localparam int F     = FRACTION_BITS;
  localparam int NW    = 3 * F + 4;
  localparam int MW    = F + 3;
  localparam int K     = F + 4;
  localparam int RECIP = ((1 << K) + 2) / 3;
  localparam int PW    = MW + K;

  localparam logic [F:0]    S_VAL = (F + 1)'(1) << F;
  localparam logic [NW-1:0] S3    = NW'(1) << (3 * F);
  localparam logic [NW-1:0] HALF  = NW'(3) << (2 * F);

  logic [4:0]          v_q;
  logic [F-1:0]        f_q;
  logic [F:0]          g_q;
  logic [2*F-1:0]      f2_q;
  logic [2*F:0]        g2_q;
  logic [3*F-1:0]      f3_q;
  logic [3*F:0]        g3_q;
  logic [3:0][MW-1:0]  m_q;
  logic [3:0][F:0]     w_q;

  logic [NW-1:0]       f3n, f2s, fs2;
  logic [3:0][NW-1:0]  n;
  logic [NW-1:0]       nh;
  logic [3:0][MW-1:0]  m_d;
  logic [PW-1:0]       pr;
  logic [3:0][F:0]     w_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[3:0], start_i};
    end
  end

  always_comb begin
    f3n  = NW'(f3_q);
    f2s  = NW'(f2_q) << F;
    fs2  = NW'(f_q) << (2 * F);
    n[0] = NW'(g3_q);
    n[1] = NW'(3) * f3n - NW'(6) * f2s + NW'(4) * S3;
    n[2] = NW'(3) * f2s + NW'(3) * fs2 + S3 - NW'(3) * f3n;
    n[3] = f3n;
    for (int k = 0; k < 4; k++) begin
      nh     = n[k] + HALF;
      m_d[k] = MW'(nh >> (2 * F + 1));
    end
  end

  // divide by three through a reciprocal
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pr     = PW'(m_q[k]) * PW'(RECIP);
      w_d[k] = pr[K +: F + 1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      f_q <= frac_i;
      g_q <= S_VAL - (F + 1)'(frac_i);
    end
    f2_q <= (2 * F)'(f_q) * (2 * F)'(f_q);
    g2_q <= (2 * F + 1)'(g_q) * (2 * F + 1)'(g_q);
    f3_q <= (3 * F)'(f2_q) * (3 * F)'(f_q);
    g3_q <= (3 * F + 1)'(g2_q) * (3 * F + 1)'(g_q);
    m_q  <= m_d;
    w_q  <= w_d;
  end

  assign done_o = v_q[4];
  assign w_o    = w_q;

endmodule
`default_nettype wire

// ----- sv/bbi_back.sv -----
// back end: knot store, weight units and the multiply-accumulate sequencer
`default_nettype none
module bbi_back #(
  parameter int KNOT_STORE_DEPTH = bbi_pkg::KNOT_STORE_DEPTH_DEF,
  parameter int FRACTION_BITS    = bbi_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic [bbi_pkg::JOB_FIXED_W+2*FRACTION_BITS-1:0] job_i,
  input  wire logic                                  empty_i,
  output logic                                       pop_o,
  input  wire logic [bbi_pkg::XCNT_W-1:0]            x_cnt_i,
  input  wire logic [bbi_pkg::YCNT_W-1:0]            y_cnt_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic signed [bbi_pkg::OUT_W-1:0]           out_value_o
);
  import bbi_pkg::*;

  localparam int F    = FRACTION_BITS;
  localparam int AW   = $clog2(KNOT_STORE_DEPTH);
  localparam int FA   = 2 * BIN_W + 1;
  localparam int P1W  = KNOT_W + F + 2;
  localparam int P2W  = P1W + F + 2;
  localparam int ACCW = P2W + 4;
  localparam int RW   = ACCW + 1 - 2 * F;

  localparam logic [ACCW:0]          RND_HALF = (ACCW + 1)'(1) << (2 * F - 1);
  localparam logic signed [RW-1:0]   OUT_MAX_V = RW'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [RW-1:0]   OUT_MIN_V = RW'(-(1 << (OUT_W - 1)));

  logic                      h_kind;
  logic [IDX_W-1:0]          h_idx;
  logic [KNOT_W-1:0]         h_val;
  logic                      h_xzero;
  logic [BIN_W-1:0]          h_bx, h_by;
  logic [F-1:0]              h_fx, h_fy;

  assign {h_kind, h_idx, h_val, h_xzero, h_bx, h_fx, h_by, h_fy} = job_i;

  back_state_e state_q, state_d;

  logic pop, ram_we, issue, load_job, load_out, wdone, wdone_y;

  logic                      xzero_q;
  logic [BIN_W-1:0]          by_q, col_q, col_d, col_start_q, col_start_d;
  logic [1:0]                a_q, b_q;

  logic                      p0_v_q, p0_ok_q;
  logic [1:0]                p0_a_q, p0_b_q;
  logic                      p1_v_q;
  logic [1:0]                p1_b_q;
  logic signed [P1W-1:0]     p1_q, p1_d;
  logic                      p2_v_q;
  logic signed [P2W-1:0]     p2_q, p2_d;
  logic signed [ACCW-1:0]    acc_q;

  logic                      out_valid_q;
  logic signed [OUT_W-1:0]   out_value_q, out_value_d;

  logic [BIN_W:0]            row_p1;
  logic [BIN_W-1:0]          row;
  logic                      row_ok;
  logic [FA-1:0]             addr;
  logic                      tap_ok;
  logic [BIN_W:0]            col_inc;

  logic [3:0][F:0]           wx, wy;
  logic [KNOT_W-1:0]         rd_data;

  logic signed [ACCW:0]      rnd;
  logic signed [RW-1:0]      rsh;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i && h_kind == KIND_QUERY) begin
          state_d = BK_WEIGH;
        end
      end
      BK_WEIGH: begin
        if (wdone && wdone_y) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (a_q == 2'd3 && b_q == 2'd3) begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (!p0_v_q && !p1_v_q && !p2_v_q) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      BK_IDLE:  pop      = !empty_i;
      BK_RUN:   issue    = 1'b1;
      BK_DONE:  load_out = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  assign pop_o    = pop;
  assign load_job = pop && (h_kind == KIND_QUERY);
  assign ram_we   = pop && (h_kind == KIND_WRITE) &&
                    (FA'(h_idx) < FA'(KNOT_STORE_DEPTH));

  bbi_ram #(
    .WIDTH (KNOT_W),
    .DEPTH (KNOT_STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(h_idx)),
    .wdata_i (h_val),
    .re_i    (issue),
    .raddr_i (AW'(addr)),
    .rdata_o (rd_data)
  );

  bbi_weights #(.FRACTION_BITS(F)) u_wx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (load_job),
    .frac_i  (h_fx),
    .done_o  (wdone),
    .w_o     (wx)
  );

  bbi_weights #(.FRACTION_BITS(F)) u_wy (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (load_job),
    .frac_i  (h_fy),
    .done_o  (wdone_y),
    .w_o     (wy)
  );

  // tap address and column walk
  always_comb begin
    row_p1      = (BIN_W + 1)'(by_q) + (BIN_W + 1)'(b_q);
    row_ok      = (row_p1 != '0) && (row_p1 <= (BIN_W + 1)'(y_cnt_i));
    row         = BIN_W'(row_p1 - (BIN_W + 1)'(1));
    addr        = FA'(row) * FA'(x_cnt_i) + FA'(col_q);
    tap_ok      = !xzero_q && row_ok && (addr < FA'(KNOT_STORE_DEPTH));
    col_inc     = (BIN_W + 1)'(col_q) + (BIN_W + 1)'(1);
    col_start_d = (h_bx == '0) ? BIN_W'(x_cnt_i) - BIN_W'(1) : h_bx - BIN_W'(1);
    if (load_job) begin
      col_d = col_start_d;
    end else if (a_q == 2'd3) begin
      col_d = col_start_q;
    end else if (col_inc == (BIN_W + 1)'(x_cnt_i)) begin
      col_d = '0;
    end else begin
      col_d = BIN_W'(col_inc);
    end
  end

  always_comb begin
    p1_d = p0_ok_q ? P1W'($signed(rd_data)) * P1W'($signed({1'b0, wx[p0_a_q]})) : '0;
    p2_d = P2W'(p1_q) * P2W'($signed({1'b0, wy[p1_b_q]}));
  end

  // round half up to the output scale and saturate
  always_comb begin
    rnd = (ACCW + 1)'(acc_q) + $signed(RND_HALF);
    rsh = RW'(rnd >>> (2 * F));
    if (rsh > OUT_MAX_V) begin
      out_value_d = OUT_W'(OUT_MAX_V);
    end else if (rsh < OUT_MIN_V) begin
      out_value_d = OUT_W'(OUT_MIN_V);
    end else begin
      out_value_d = OUT_W'(rsh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      a_q         <= '0;
      b_q         <= '0;
      p0_v_q      <= 1'b0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_job) begin
        a_q <= '0;
        b_q <= '0;
      end else if (issue) begin
        a_q <= a_q + 2'd1;
        if (a_q == 2'd3) begin
          b_q <= b_q + 2'd1;
        end
      end
      p0_v_q <= issue;
      p1_v_q <= p0_v_q;
      p2_v_q <= p1_v_q;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_job) begin
      xzero_q     <= h_xzero;
      by_q        <= h_by;
      col_start_q <= col_start_d;
    end
    if (load_job || issue) begin
      col_q <= col_d;
    end
    p0_ok_q <= tap_ok;
    p0_a_q  <= a_q;
    p0_b_q  <= b_q;
    p1_b_q  <= p0_b_q;
    p1_q    <= p1_d;
    p2_q    <= p2_d;
    if (load_job) begin
      acc_q <= '0;
    end else if (p2_v_q) begin
      acc_q <= acc_q + ACCW'(p2_q);
    end
    if (load_out) begin
      out_value_q <= out_value_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;

endmodule
`default_nettype wire

// ----- sv/bicubic_bspline_interpolator.sv -----
// top level of the bicubic uniform b-spline interpolator
// A knot write word stores one signed Q4.12 knot at row * x_knot_count + column
// and is written into the knot store as the back end takes it from the queue.
// A query word is scaled into bin space in the front end, queued, and then
// goes through the back end in order: it is taken from the queue, the weight
// pipelines run, sixteen neighbour reads go through the single read port of
// the knot store (one per cycle), the multiply-accumulate pipeline drains and
// the result is posted. The front end keeps accepting words into a four entry
// queue while a query is worked on. Knots must be written before any query
// reads them; there is no clearing pass after reset.
`default_nettype none
module bicubic_bspline_interpolator #(
  parameter int KNOT_STORE_DEPTH = bbi_pkg::KNOT_STORE_DEPTH_DEF,
  parameter int FRACTION_BITS    = bbi_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               kind_i,
  input  wire logic [bbi_pkg::IDX_W-1:0]          knot_index_i,
  input  wire logic signed [bbi_pkg::KNOT_W-1:0]  knot_value_i,
  input  wire logic [bbi_pkg::COORD_W-1:0]        point_x_i,
  input  wire logic [bbi_pkg::COORD_W-1:0]        point_y_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [bbi_pkg::OUT_W-1:0]        interpolated_value_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [bbi_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [bbi_pkg::CFG_W-1:0]          cfg_data_i
);
  import bbi_pkg::*;

  localparam int JOB_W = JOB_FIXED_W + 2 * FRACTION_BITS;

  logic [COORD_W-1:0] origin_x_q, origin_y_q;
  logic [SCALE_W-1:0] x_scale_q, y_scale_q;
  logic [XCNT_W-1:0]  x_cnt_q;
  logic [YCNT_W-1:0]  y_cnt_q;

  logic             push, full, pop, empty;
  logic [JOB_W-1:0] job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= ORIGIN_X_RST;
      origin_y_q <= ORIGIN_Y_RST;
      x_scale_q  <= X_SCALE_RST;
      y_scale_q  <= Y_SCALE_RST;
      x_cnt_q    <= X_KNOT_CNT_RST;
      y_cnt_q    <= Y_KNOT_CNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ORIGIN_X:   origin_x_q <= cfg_data_i[COORD_W-1:0];
        CFG_ORIGIN_Y:   origin_y_q <= cfg_data_i[COORD_W-1:0];
        CFG_X_SCALE:    x_scale_q  <= cfg_data_i[SCALE_W-1:0];
        CFG_Y_SCALE:    y_scale_q  <= cfg_data_i[SCALE_W-1:0];
        CFG_X_KNOT_CNT: x_cnt_q    <= cfg_data_i[XCNT_W-1:0];
        CFG_Y_KNOT_CNT: y_cnt_q    <= cfg_data_i[YCNT_W-1:0];
        default: ;
      endcase
    end
  end

  bbi_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .knot_index_i (knot_index_i),
    .knot_value_i (knot_value_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .origin_x_i   (origin_x_q),
    .origin_y_i   (origin_y_q),
    .x_scale_i    (x_scale_q),
    .y_scale_i    (y_scale_q),
    .x_cnt_i      (x_cnt_q),
    .y_cnt_i      (y_cnt_q),
    .full_i       (full),
    .push_o       (push),
    .job_o        (job_in)
  );

  bbi_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (job_out),
    .empty_o (empty)
  );

  bbi_back #(
    .KNOT_STORE_DEPTH (KNOT_STORE_DEPTH),
    .FRACTION_BITS    (FRACTION_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .empty_i     (empty),
    .pop_o       (pop),
    .x_cnt_i     (x_cnt_q),
    .y_cnt_i     (y_cnt_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_value_o (interpolated_value_o)
  );

endmodule
`default_nettype wire

// ----- sv/bbi_checker.sv -----
// port level checks of the interpolator and their binding
`default_nettype none
module bbi_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_stall_o,
  input wire logic                               kind_i,
  input wire logic [bbi_pkg::IDX_W-1:0]          knot_index_i,
  input wire logic signed [bbi_pkg::KNOT_W-1:0]  knot_value_i,
  input wire logic [bbi_pkg::COORD_W-1:0]        point_x_i,
  input wire logic [bbi_pkg::COORD_W-1:0]        point_y_i,
  input wire logic                               out_valid_o,
  input wire logic                               out_stall_i,
  input wire logic signed [bbi_pkg::OUT_W-1:0]   interpolated_value_o,
  input wire logic                               cfg_we_i,
  input wire logic [bbi_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input wire logic [bbi_pkg::CFG_W-1:0]          cfg_data_i
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(interpolated_value_o))
    else $error("result word changed under stall");

  // leaving reset the block is empty and ready
  a_reset_clean: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("block not empty after reset");

  // input stall only comes up after a word was taken
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall raised without a word taken");

endmodule

bind bicubic_bspline_interpolator bbi_checker u_bbi_checker (.*);
`default_nettype wire
